@@ hw/rtl/rfa_pkg.sv @@
// Shared types and constants for the reference-counted page frame allocator.
// Used by rfa_ctrl and the top level; depends on nothing else.
package rfa_pkg;

  localparam int CMD_W      = 2;
  localparam int PAGE_W     = 12;
  localparam int STATUS_W   = 3;
  localparam int COUNT_W    = 8;
  localparam int REG_W      = 13;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 40;

  localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ADD     = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OOM   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UNREF = 3'd3;
  localparam logic [STATUS_W-1:0] ST_SAT   = 3'd4;

  localparam logic [COUNT_W-1:0] REF_MAX = 8'd255;
  localparam logic [COUNT_W-1:0] REF_TOP = 8'd254;

  localparam logic CFG_FIRST = 1'b0;
  localparam logic CFG_LIMIT = 1'b1;

  localparam logic [REG_W-1:0] LIMIT_RESET = 13'd4096;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_COUNT,
    S_START,
    S_SCAN,
    S_MOD,
    S_USED,
    S_RESP
  } rfa_state_t;

  typedef struct packed {
    logic [REG_W-1:0] first;
    logic [REG_W-1:0] limit;
    logic             wr;
  } rfa_cfg_t;

  typedef struct packed {
    logic [REG_W-1:0]    free;
    logic [COUNT_W-1:0]  count;
    logic [PAGE_W-1:0]   page;
    logic [STATUS_W-1:0] status;
  } rfa_result_t;

endpackage

@@ hw/rtl/rfa_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; contents are not reset.
module rfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/rfa_ctrl.sv @@
// Sequencer and shared increment/decrement unit of the page frame allocator.
// Depends on rfa_pkg; drives the count RAM (rfa_ram) through its ports.
module rfa_ctrl
  import rfa_pkg::*;
#(
  parameter int NUM_PAGES = 4096
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rfa_cfg_t                     cfg,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [CMD_W-1:0]             in_cmd,
  input  logic [PAGE_W-1:0]            in_idx,
  output logic                         res_valid,
  input  logic                         res_take,
  output rfa_result_t                  res,
  output logic                         ram_we,
  output logic [$clog2(NUM_PAGES)-1:0] ram_waddr,
  output logic [COUNT_W-1:0]           ram_wdata,
  output logic [$clog2(NUM_PAGES)-1:0] ram_raddr,
  input  logic [COUNT_W-1:0]           ram_rdata
);

  localparam int AW = $clog2(NUM_PAGES);
  localparam int CW = (AW + 1 > REG_W) ? AW + 1 : REG_W;
  localparam logic [CW-1:0] NPAGES = CW'(NUM_PAGES);

  rfa_state_t state_r, state_nxt;
  logic [CW-1:0]       ptr_r, ptr_nxt;
  logic [CW-1:0]       chk_ptr_r, chk_ptr_nxt;
  logic                chk_v_r, chk_v_nxt;
  logic [REG_W-1:0]    acc_r, acc_nxt;
  logic [REG_W-1:0]    used_r, used_nxt;
  logic                dirty_r, dirty_nxt;
  logic                used_dec_r, used_dec_nxt;
  logic [CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [PAGE_W-1:0]   idx_r, idx_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [PAGE_W-1:0]   page_r, page_nxt;
  logic [COUNT_W-1:0]  cnt_r, cnt_nxt;

  logic [CW-1:0] first_c, limit_c, lim, span, idx_c;
  logic          in_rng;
  logic [CW-1:0] alu_a, alu_y;
  logic          alu_dec;

  assign first_c = CW'(cfg.first);
  assign limit_c = CW'(cfg.limit);
  assign lim     = (limit_c < NPAGES) ? limit_c : NPAGES;
  assign span    = (first_c < lim) ? lim - first_c : '0;
  assign idx_c   = CW'(idx_r);
  assign in_rng  = (idx_c >= first_c) && (idx_c < lim);

  // Shared adder: steps the scan pointer, a page count or the used total.
  assign alu_y = alu_a + (alu_dec ? {CW{1'b1}} : CW'(1));

  assign res.status = status_r;
  assign res.page   = page_r;
  assign res.count  = cnt_r;
  assign res.free   = span[REG_W-1:0] - used_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      ptr_r   <= '0;
      chk_v_r <= 1'b0;
      used_r  <= '0;
      dirty_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ptr_r   <= ptr_nxt;
      chk_v_r <= chk_v_nxt;
      used_r  <= used_nxt;
      dirty_r <= dirty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_ptr_r  <= chk_ptr_nxt;
    acc_r      <= acc_nxt;
    used_dec_r <= used_dec_nxt;
    cmd_r      <= cmd_nxt;
    idx_r      <= idx_nxt;
    status_r   <= status_nxt;
    page_r     <= page_nxt;
    cnt_r      <= cnt_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    ptr_nxt      = ptr_r;
    chk_ptr_nxt  = chk_ptr_r;
    chk_v_nxt    = chk_v_r;
    acc_nxt      = acc_r;
    used_nxt     = used_r;
    dirty_nxt    = dirty_r;
    used_dec_nxt = used_dec_r;
    cmd_nxt      = cmd_r;
    idx_nxt      = idx_r;
    status_nxt   = status_r;
    page_nxt     = page_r;
    cnt_nxt      = cnt_r;
    ram_we       = 1'b0;
    ram_waddr    = ptr_r[AW-1:0];
    ram_wdata    = '0;
    ram_raddr    = ptr_r[AW-1:0];
    alu_a        = ptr_r;
    alu_dec      = 1'b0;
    in_ready     = 1'b0;
    res_valid    = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        ram_we  = 1'b1;
        ptr_nxt = alu_y;
        if (ptr_r == NPAGES - CW'(1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_nxt   = in_cmd;
          idx_nxt   = in_idx;
          ptr_nxt   = first_c;
          chk_v_nxt = 1'b0;
          acc_nxt   = '0;
          state_nxt = dirty_r ? S_COUNT : S_START;
        end
      end

      // A register was written: recount the used pages of the managed range, one read a cycle.
      S_COUNT: begin
        if (chk_v_r && (ram_rdata != '0)) begin
          acc_nxt = acc_r + REG_W'(1);
        end
        if (ptr_r < lim) begin
          ptr_nxt   = alu_y;
          chk_v_nxt = 1'b1;
        end else begin
          chk_v_nxt = 1'b0;
          if (!chk_v_r) begin
            used_nxt  = acc_r;
            dirty_nxt = 1'b0;
            state_nxt = S_START;
          end
        end
      end

      S_START: begin
        ptr_nxt    = first_c;
        chk_v_nxt  = 1'b0;
        page_nxt   = idx_r;
        cnt_nxt    = '0;
        status_nxt = ST_RANGE;
        unique case (cmd_r)
          CMD_ALLOC: begin
            state_nxt = S_SCAN;
          end
          CMD_RELEASE, CMD_ADD: begin
            ram_raddr = idx_c[AW-1:0];
            state_nxt = in_rng ? S_MOD : S_RESP;
          end
          default: begin
            state_nxt = S_RESP;
          end
        endcase
      end

      // First-fit search: the read for one page overlaps the check of the last.
      S_SCAN: begin
        priority if (chk_v_r && (ram_rdata == '0)) begin
          ram_we       = 1'b1;
          ram_waddr    = chk_ptr_r[AW-1:0];
          ram_wdata    = COUNT_W'(1);
          status_nxt   = ST_OK;
          page_nxt     = chk_ptr_r[PAGE_W-1:0];
          cnt_nxt      = COUNT_W'(1);
          used_dec_nxt = 1'b0;
          state_nxt    = S_USED;
        end else if (ptr_r < lim) begin
          chk_ptr_nxt = ptr_r;
          chk_v_nxt   = 1'b1;
          ptr_nxt     = alu_y;
        end else begin
          status_nxt = ST_OOM;
          page_nxt   = '0;
          cnt_nxt    = '0;
          state_nxt  = S_RESP;
        end
      end

      S_MOD: begin
        alu_a     = CW'(ram_rdata);
        alu_dec   = (cmd_r == CMD_RELEASE);
        ram_waddr = idx_c[AW-1:0];
        ram_wdata = alu_y[COUNT_W-1:0];
        state_nxt = S_RESP;
        priority if (ram_rdata == '0) begin
          status_nxt = ST_UNREF;
        end else if (cmd_r == CMD_RELEASE) begin
          ram_we     = 1'b1;
          status_nxt = ST_OK;
          cnt_nxt    = alu_y[COUNT_W-1:0];
          if (ram_rdata == COUNT_W'(1)) begin
            used_dec_nxt = 1'b1;
            state_nxt    = S_USED;
          end
        end else if (ram_rdata >= REF_TOP) begin
          status_nxt = ST_SAT;
          cnt_nxt    = ram_rdata;
        end else begin
          ram_we     = 1'b1;
          status_nxt = ST_OK;
          cnt_nxt    = alu_y[COUNT_W-1:0];
        end
      end

      S_USED: begin
        alu_a     = CW'(used_r);
        alu_dec   = used_dec_r;
        used_nxt  = alu_y[REG_W-1:0];
        state_nxt = S_RESP;
      end

      S_RESP: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg.wr) begin
      dirty_nxt = 1'b1;
    end
  end

endmodule

@@ hw/rtl/refcounted_page_frame_allocator.sv @@
// Reference-counted page frame allocator: one 8-bit count per page frame in a RAM,
// worked by a small sequencer that handles one command at a time. After reset a
// clearing pass writes every count to zero, with in_tready low throughout. A release
// or an add reads the count, then modifies and writes it, then the result passes to
// the output register; when a page becomes free the used total is stepped as well.
// A page outside the managed range or an unknown command skips the modify and write.
// An allocate scans the managed range from its first page, reading one count per
// cycle from the single read port, and takes the first free page; a full range with
// no free page answers out-of-memory once the whole range is read. The first command
// after a register write first recounts the managed range. A finished result sits in
// the output register, so the next command is taken while it waits.
// Depends on rfa_pkg, rfa_ctrl and rfa_ram.
module refcounted_page_frame_allocator
  import rfa_pkg::*;
#(
  parameter int NUM_PAGES = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic                  cfg_addr,
  input  logic [REG_W-1:0]      cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // command [1:0], page_index [13:2], zero [15:14]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // status [2:0], result_page [14:3], ref_count [22:15], free_count [35:23], zero [39:36]
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int AW = $clog2(NUM_PAGES);

  logic [REG_W-1:0]      first_r, limit_r;
  logic                  out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;

  rfa_cfg_t           cfg;
  rfa_result_t        res;
  logic               res_valid, res_take;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [COUNT_W-1:0] ram_wdata, ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= '0;
      limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_FIRST: first_r <= cfg_wdata;
        CFG_LIMIT: limit_r <= cfg_wdata;
        default:   first_r <= first_r;
      endcase
    end
  end

  assign cfg.first = first_r;
  assign cfg.limit = limit_r;
  assign cfg.wr    = cfg_we;

  // The output register frees up in the same cycle its beat is taken.
  assign res_take = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_take) begin
      out_tvalid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      out_tdata_r <= {{(OUT_DATA_W - $bits(rfa_result_t)){1'b0}}, res};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  rfa_ctrl #(
    .NUM_PAGES (NUM_PAGES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_cmd    (in_tdata[CMD_W-1:0]),
    .in_idx    (in_tdata[CMD_W+PAGE_W-1:CMD_W]),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  rfa_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (NUM_PAGES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Only one command is in flight: a taken beat drops ready for the next cycle.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while a command is still in flight");

  a_oom_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[STATUS_W-1:0] == ST_OOM)) |->
      (out_tdata[STATUS_W+PAGE_W+COUNT_W-1:STATUS_W] == '0))
    else $error("out-of-memory result carries a page or a count");

  a_count_below_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[STATUS_W+PAGE_W+COUNT_W-1:STATUS_W+PAGE_W] != REF_MAX))
    else $error("reference count reached its forbidden maximum");

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for refcounted_page_frame_allocator: directed and random
// command streams on the input channel, every response checked against a local model.
// Depends on rfa_pkg and the allocator RTL.
module testbench;
  import rfa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_PAGES = 4096;
  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic                  cfg_addr;
  logic [REG_W-1:0]      cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  // Local mirror of the allocator state and its two registers.
  logic [COUNT_W-1:0] page_count [NUM_PAGES];
  int                 range_first;
  int                 range_limit;

  rfa_result_t        pending_answers [$];
  logic [PAGE_W-1:0]  held_pages [$];
  int                 bad_fields;
  int                 burst_left;
  int                 gap_len;

  refcounted_page_frame_allocator #(
    .NUM_PAGES(NUM_PAGES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("testbench: errors");
    $finish;
  end

  function automatic int managed_limit();
    return (range_limit < NUM_PAGES) ? range_limit : NUM_PAGES;
  endfunction

  // Applies one command to the mirror and returns the response it should produce.
  function automatic rfa_result_t apply_command(input logic [CMD_W-1:0] cmd,
                                                input logic [PAGE_W-1:0] pg);
    rfa_result_t ans;
    int lim;
    int c;
    int used;
    int span;
    lim = managed_limit();
    ans.status = ST_RANGE;
    ans.page   = pg;
    ans.count  = '0;
    if (cmd == CMD_ALLOC) begin
      ans.status = ST_OOM;
      ans.page   = '0;
      for (int i = range_first; i < lim; i++) begin
        if (page_count[i] == '0) begin
          page_count[i] = 8'd1;
          ans.status    = ST_OK;
          ans.page      = PAGE_W'(i);
          ans.count     = 8'd1;
          break;
        end
      end
    end else if (cmd == CMD_RELEASE || cmd == CMD_ADD) begin
      if (int'(pg) >= range_first && int'(pg) < lim) begin
        c = page_count[pg];
        if (c == 0) begin
          ans.status = ST_UNREF;
        end else if (cmd == CMD_RELEASE) begin
          c--;
          page_count[pg] = COUNT_W'(c);
          ans.status     = ST_OK;
          ans.count      = COUNT_W'(c);
        end else if (c + 1 >= int'(REF_MAX)) begin
          ans.status = ST_SAT;
          ans.count  = COUNT_W'(c);
        end else begin
          c++;
          page_count[pg] = COUNT_W'(c);
          ans.status     = ST_OK;
          ans.count      = COUNT_W'(c);
        end
      end
    end
    used = 0;
    span = 0;
    for (int i = range_first; i < lim; i++) begin
      span++;
      if (page_count[i] != '0) used++;
    end
    ans.free = REG_W'(span - used);
    return ans;
  endfunction

  // Most commands address pages handed out recently, so counts actually move.
  function automatic logic [PAGE_W-1:0] pick_page();
    int r;
    int lim;
    r   = $urandom_range(0, 99);
    lim = managed_limit();
    if (r < 60 && held_pages.size() != 0)
      return held_pages[$urandom_range(0, held_pages.size() - 1)];
    if (r < 85 && range_first < lim)
      return PAGE_W'($urandom_range(range_first, lim - 1));
    return PAGE_W'($urandom_range(0, NUM_PAGES - 1));
  endfunction

  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [PAGE_W-1:0] pg);
    rfa_result_t ans;
    in_tdata  <= {2'b00, pg, cmd};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    ans = apply_command(cmd, pg);
    pending_answers.push_back(ans);
    if (cmd == CMD_ALLOC && ans.status == ST_OK) begin
      held_pages.push_back(ans.page);
      if (held_pages.size() > 48) void'(held_pages.pop_front());
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap_len    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap_len > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap_len) @(posedge clk);
      end
    end
  endtask

  task automatic send_random(input int alloc_w, input int rel_w, input int add_w);
    int r;
    logic [CMD_W-1:0] cmd;
    r = $urandom_range(0, 99);
    if (r < alloc_w)                      cmd = CMD_ALLOC;
    else if (r < alloc_w + rel_w)         cmd = CMD_RELEASE;
    else if (r < alloc_w + rel_w + add_w) cmd = CMD_ADD;
    else                                  cmd = CMD_W'($urandom_range(0, 3));
    send_cmd(cmd, pick_page());
  endtask

  task automatic wait_for_answers();
    in_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  // Registers are only written with the allocator idle.
  task automatic set_range(input int first, input int limit);
    wait_for_answers();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_FIRST;
    cfg_wdata <= REG_W'(first);
    @(posedge clk);
    cfg_addr  <= CFG_LIMIT;
    cfg_wdata <= REG_W'(limit);
    @(posedge clk);
    cfg_we      <= 1'b0;
    range_first = first;
    range_limit = limit;
    held_pages.delete();
  endtask

  task automatic test_basic_commands();
    send_cmd(CMD_ALLOC, 12'h000);
    send_cmd(CMD_ALLOC, 12'h000);
    send_cmd(CMD_ALLOC, 12'hFFF);
    send_cmd(CMD_ADD, 12'h000);
    send_cmd(CMD_RELEASE, 12'h001);
    send_cmd(CMD_ALLOC, 12'h555);
    send_cmd(CMD_RELEASE, 12'hFFF);
    send_cmd(CMD_ADD, 12'hFFF);
    send_cmd(CMD_NONE, 12'hABC);
    send_cmd(CMD_RELEASE, 12'h002);
    send_cmd(CMD_RELEASE, 12'h002);
  endtask

  task automatic test_range_limits();
    set_range(4095, 4096);
    send_cmd(CMD_ALLOC, 12'h000);
    send_cmd(CMD_ALLOC, 12'h000);
    send_cmd(CMD_ADD, 12'hFFE);
    send_cmd(CMD_ADD, 12'hFFF);
    send_cmd(CMD_RELEASE, 12'hFFF);
    set_range(8, 12);
    repeat (5) send_cmd(CMD_ALLOC, 12'h000);
    send_cmd(CMD_RELEASE, 12'd7);
    send_cmd(CMD_ADD, 12'd12);
    // Nothing is managed once the first page reaches the limit.
    set_range(4096, 4096);
    send_cmd(CMD_ALLOC, 12'h000);
    send_cmd(CMD_RELEASE, 12'hFFF);
    set_range(0, 0);
    send_cmd(CMD_ALLOC, 12'h000);
    send_cmd(CMD_ADD, 12'h000);
  endtask

  // A single managed page, mostly shared, so its count climbs to the ceiling.
  task automatic test_saturation();
    set_range(4095, 4096);
    held_pages.push_back(12'hFFF);
    repeat (420) send_random(2, 4, 92);
  endtask

  task automatic test_small_ranges();
    int first;
    repeat (5) begin
      first = $urandom_range(0, 4080);
      set_range(first, first + $urandom_range(4, 16));
      repeat (55) send_random(40, 25, 25);
    end
  endtask

  task automatic test_full_range();
    set_range(0, 4096);
    repeat (90) send_random(35, 30, 25);
    // Let the pipeline run dry once mid-stream before carrying on.
    wait_for_answers();
    repeat (90) send_random(35, 30, 25);
  endtask

  task automatic test_empty_range();
    int first;
    first = $urandom_range(1, 4096);
    set_range(first, $urandom_range(0, first));
    repeat (20) send_random(40, 25, 25);
  endtask

  initial begin
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_addr   = CFG_FIRST;
    cfg_wdata  = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    bad_fields = 0;
    burst_left = 0;
    gap_len    = 0;
    range_first = 0;
    range_limit = int'(LIMIT_RESET);
    foreach (page_count[i]) page_count[i] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_basic_commands();
    test_range_limits();
    test_saturation();
    test_small_ranges();
    test_full_range();
    test_empty_range();
    wait_for_answers();
    repeat (40) @(posedge clk);
    if (bad_fields == 0 && pending_answers.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // The receiver switches between always ready, light and heavy stalling.
  initial begin : result_sink
    int mode;
    int len;
    out_tready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      len  = $urandom_range(8, 80);
      repeat (len) begin
        @(posedge clk);
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          2: out_tready <= ($urandom_range(0, 7) == 0);
          default: out_tready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : check_answers
    rfa_result_t got;
    rfa_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[35:0];
      if (pending_answers.size() == 0) begin
        $error("response beat with nothing outstanding: %h", out_tdata);
        bad_fields++;
      end else begin
        want = pending_answers.pop_front();
        if (got.status != want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          bad_fields++;
        end
        if (got.page != want.page) begin
          $error("result_page: expected %0d, got %0d", want.page, got.page);
          bad_fields++;
        end
        if (got.count != want.count) begin
          $error("ref_count: expected %0d, got %0d", want.count, got.count);
          bad_fields++;
        end
        if (got.free != want.free) begin
          $error("free_count: expected %0d, got %0d", want.free, got.free);
          bad_fields++;
        end
      end
    end
  end

endmodule
